// ===== rtl/core/idti_pkg.sv =====
// Shared types, codes and the sequencer microprogram of the IR distance table interpolator.
package idti_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned PROD_W   = DIST_W + SAMPLE_W;
  localparam int unsigned ENTRY_W  = DIST_W + SAMPLE_W;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned EIU_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_NEAR    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAR     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSEG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DISTANCE   = 2'd1;

  localparam logic [EIU_W-1:0]  EIU_RESET = 5'd10;
  localparam logic [DIST_W-1:0] FAR_RESET = 16'd15360;

  localparam logic [CNT_W-1:0] DIV_LAST_CNT = 4'd15;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_FIRST    = 4'd0;
  localparam step_t STEP_CHK0     = 4'd1;
  localparam step_t STEP_CHKL     = 4'd2;
  localparam step_t STEP_SCAN     = 4'd3;
  localparam step_t STEP_LOOP     = 4'd4;
  localparam step_t STEP_NOSEG    = 4'd5;
  localparam step_t STEP_MUL      = 4'd6;
  localparam step_t STEP_DIVINIT  = 4'd7;
  localparam step_t STEP_DIV      = 4'd8;
  localparam step_t STEP_INTERP   = 4'd9;
  localparam step_t STEP_NEAR     = 4'd10;
  localparam step_t STEP_FAR      = 4'd11;
  localparam step_t STEP_WRITTEN  = 4'd12;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FIRST,
    RD_LAST,
    RD_SEG1,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH_HI,
    A_CLR_IDX,
    A_SCAN,
    A_MUL,
    A_DIV_INIT,
    A_DIV_STEP,
    A_RES_NEAR,
    A_RES_FAR,
    A_RES_INTERP,
    A_RES_NOSEG,
    A_RES_WRITTEN
  } act_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NEAR,
    C_FAR,
    C_HIT,
    C_MORE,
    C_DIV_MORE
  } cond_e;

  typedef struct packed {
    rd_sel_e rd;
    act_e    act;
    cond_e   cond;
    step_t   target;
    logic    last;
  } uword_t;

  typedef struct packed {
    logic near;
    logic far;
    logic hit;
    logic more;
    logic div_more;
    logic out_full;
  } flags_t;

  localparam uword_t UWORD_NOP = '{rd: RD_NONE, act: A_NONE, cond: C_NEVER,
                                   target: STEP_FIRST, last: 1'b1};

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = UWORD_NOP;
    case (s)
      STEP_FIRST: w = '{rd: RD_FIRST, act: A_NONE, cond: C_NEVER,
                        target: STEP_FIRST, last: 1'b0};
      STEP_CHK0: w = '{rd: RD_LAST, act: A_LATCH_HI, cond: C_NEAR,
                       target: STEP_NEAR, last: 1'b0};
      STEP_CHKL: w = '{rd: RD_SEG1, act: A_CLR_IDX, cond: C_FAR,
                       target: STEP_FAR, last: 1'b0};
      STEP_SCAN: w = '{rd: RD_NEXT, act: A_SCAN, cond: C_HIT,
                       target: STEP_MUL, last: 1'b0};
      STEP_LOOP: w = '{rd: RD_NONE, act: A_NONE, cond: C_MORE,
                       target: STEP_SCAN, last: 1'b0};
      STEP_NOSEG: w = '{rd: RD_NONE, act: A_RES_NOSEG, cond: C_NEVER,
                        target: STEP_FIRST, last: 1'b1};
      STEP_MUL: w = '{rd: RD_NONE, act: A_MUL, cond: C_NEVER,
                      target: STEP_FIRST, last: 1'b0};
      STEP_DIVINIT: w = '{rd: RD_NONE, act: A_DIV_INIT, cond: C_NEVER,
                          target: STEP_FIRST, last: 1'b0};
      STEP_DIV: w = '{rd: RD_NONE, act: A_DIV_STEP, cond: C_DIV_MORE,
                      target: STEP_DIV, last: 1'b0};
      STEP_INTERP: w = '{rd: RD_NONE, act: A_RES_INTERP, cond: C_NEVER,
                         target: STEP_FIRST, last: 1'b1};
      STEP_NEAR: w = '{rd: RD_NONE, act: A_RES_NEAR, cond: C_NEVER,
                       target: STEP_FIRST, last: 1'b1};
      STEP_FAR: w = '{rd: RD_NONE, act: A_RES_FAR, cond: C_NEVER,
                      target: STEP_FIRST, last: 1'b1};
      STEP_WRITTEN: w = '{rd: RD_NONE, act: A_RES_WRITTEN, cond: C_NEVER,
                          target: STEP_FIRST, last: 1'b1};
      default: w = UWORD_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/idti_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module idti_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/idti_useq.sv =====
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module idti_useq import idti_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  logic   write_i,
  input  flags_t flags_i,
  output uword_t uword_o,
  output logic   busy_o
);

  step_t  step_q;
  logic   busy_q;
  uword_t word;
  logic   jump;
  logic   stall;

  assign word = ucode(step_q);

  always_comb begin
    case (word.cond)
      C_NEVER:    jump = 1'b0;
      C_NEAR:     jump = flags_i.near;
      C_FAR:      jump = flags_i.far;
      C_HIT:      jump = flags_i.hit;
      C_MORE:     jump = flags_i.more;
      C_DIV_MORE: jump = flags_i.div_more;
      default:    jump = 1'b0;
    endcase
  end

  assign stall = word.last && flags_i.out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_FIRST;
    end else if (!busy_q) begin
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= write_i ? STEP_WRITTEN : STEP_FIRST;
      end
    end else if (!stall) begin
      if (word.last) begin
        busy_q <= 1'b0;
      end else if (jump) begin
        step_q <= word.target;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  assign uword_o = busy_q ? word : UWORD_NOP;
  assign busy_o  = busy_q;

endmodule

// ===== rtl/core/idti_dpath.sv =====
// Datapath: calibration table RAM, segment registers, multiplier, serial divider, result register.
module idti_dpath import idti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uword_t              uword_i,
  output flags_t              flags_o,
  input  logic                accept_i,
  input  logic                opcode_i,
  input  logic [INDEX_W-1:0]  entry_index_i,
  input  logic [SAMPLE_W-1:0] raw_sample_i,
  input  logic [DIST_W-1:0]   entry_distance_i,
  input  logic [EIU_W-1:0]    entries_in_use_i,
  input  logic [DIST_W-1:0]   far_distance_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [DIST_W-1:0]   distance_out_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  logic [NW-1:0]       n;
  logic [NW-1:0]       i_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] hi_q;
  logic [SAMPLE_W-1:0] lo_q;
  logic [DIST_W-1:0]   dhi_q;
  logic [DIST_W-1:0]   dlo_q;
  logic                neg_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] den_q;
  logic [SAMPLE_W-1:0] rem_q;
  logic [DIST_W-1:0]   quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [STATUS_W-1:0] out_status_q;

  logic                we;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [DIST_W-1:0]   rd_dist;
  logic [DIST_W-1:0]   abs_diff;
  logic [SAMPLE_W-1:0] offset;
  logic [SAMPLE_W:0]   trial;
  logic                ge;
  logic [SAMPLE_W:0]   trial_sub;
  logic                res_en;
  flags_t              flags;

  always_comb begin
    if (entries_in_use_i < EIU_W'(2)) begin
      n = NW'(2);
    end else if (32'(entries_in_use_i) > TABLE_DEPTH) begin
      n = NW'(TABLE_DEPTH);
    end else begin
      n = NW'(entries_in_use_i);
    end
  end

  assign we = accept_i && (opcode_i == OP_WRITE) && (32'(entry_index_i) < TABLE_DEPTH);

  always_comb begin
    case (uword_i.rd)
      RD_FIRST: raddr = '0;
      RD_LAST:  raddr = AW'(n - NW'(1));
      RD_SEG1:  raddr = AW'(1);
      RD_NEXT:  raddr = AW'({1'b0, i_q} + (NW + 1)'(2));
      default:  raddr = '0;
    endcase
  end

  assign re = (uword_i.rd != RD_NONE) && !((uword_i.rd == RD_NEXT) && flags.hit);

  idti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_distance_i, raw_sample_i}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_sample = rdata[SAMPLE_W-1:0];
  assign rd_dist   = rdata[ENTRY_W-1:SAMPLE_W];

  assign flags.near     = sample_q >= rd_sample;
  assign flags.far      = sample_q <= rd_sample;
  assign flags.hit      = (sample_q <= hi_q) && (sample_q > rd_sample);
  assign flags.more     = i_q < (n - NW'(1));
  assign flags.div_more = cnt_q != '0;
  assign flags.out_full = out_valid_q && !out_ready_i;
  assign flags_o        = flags;

  assign abs_diff  = (dlo_q < dhi_q) ? (dhi_q - dlo_q) : (dlo_q - dhi_q);
  assign offset    = hi_q - sample_q;
  assign trial     = {rem_q, quo_q[DIST_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign res_en    = !flags.out_full;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sample_q <= raw_sample_i;
    end
    case (uword_i.act)
      A_LATCH_HI: begin
        hi_q  <= rd_sample;
        dhi_q <= rd_dist;
      end
      A_CLR_IDX: begin
        i_q <= '0;
      end
      A_SCAN: begin
        if (flags.hit) begin
          lo_q  <= rd_sample;
          dlo_q <= rd_dist;
        end else begin
          hi_q  <= rd_sample;
          dhi_q <= rd_dist;
          i_q   <= i_q + NW'(1);
        end
      end
      A_MUL: begin
        prod_q <= PROD_W'(abs_diff) * PROD_W'(offset);
        den_q  <= hi_q - lo_q;
        neg_q  <= dlo_q < dhi_q;
      end
      A_DIV_INIT: begin
        rem_q <= prod_q[PROD_W-1:DIST_W];
        quo_q <= prod_q[DIST_W-1:0];
        cnt_q <= DIV_LAST_CNT;
      end
      A_DIV_STEP: begin
        rem_q <= ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        quo_q <= {quo_q[DIST_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_en && (uword_i.act inside {A_RES_NEAR, A_RES_FAR, A_RES_INTERP,
                                                A_RES_NOSEG, A_RES_WRITTEN})) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      case (uword_i.act)
        A_RES_NEAR: begin
          out_dist_q   <= dhi_q;
          out_status_q <= ST_NEAR;
        end
        A_RES_FAR: begin
          out_dist_q   <= far_distance_i;
          out_status_q <= ST_FAR;
        end
        A_RES_INTERP: begin
          out_dist_q   <= neg_q ? (dhi_q - quo_q) : (dhi_q + quo_q);
          out_status_q <= ST_INTERP;
        end
        A_RES_NOSEG: begin
          out_dist_q   <= '0;
          out_status_q <= ST_NOSEG;
        end
        A_RES_WRITTEN: begin
          out_dist_q   <= '0;
          out_status_q <= ST_WRITTEN;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign distance_out_o = out_dist_q;
  assign status_o       = out_status_q;

endmodule

// ===== rtl/core/ir_distance_table_interpolator.sv =====
// IR distance table interpolator top level: stream ports, configuration registers, sequencer.
// One item in flight; the next item is accepted the cycle after the result is registered.
// A write goes straight to its written step; a conversion checks the near clamp against entry 0,
// then the far clamp against the last entry in use, then scans the segments one entry at a time
// and, on a hit, multiplies and runs the 16-step serial divider; no hit gives no segment.
// Reset clears control and config (entries in use 10, far distance 60.0); the table is
// undefined until written and has no clearing pass.
module ir_distance_table_interpolator import idti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_index[3:0], raw_sample[15:4], entry_distance[31:16]
  input  logic [31:0]          s_axis_tdata,
  // opcode[0]
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // distance_out[15:0]
  output logic [15:0]          m_axis_tdata,
  // status[2:0]
  output logic [2:0]           m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIST_W-1:0]    cfg_data_i
);

  logic [EIU_W-1:0]  eiu_q;
  logic [DIST_W-1:0] far_q;
  logic              busy;
  logic              accept;
  uword_t            uword;
  flags_t            flags;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q <= EIU_RESET;
      far_q <= FAR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENTRIES_IN_USE: eiu_q <= cfg_data_i[EIU_W-1:0];
        CFG_FAR_DISTANCE:   far_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  idti_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .write_i (s_axis_tuser[0] == OP_WRITE),
    .flags_i (flags),
    .uword_o (uword),
    .busy_o  (busy)
  );

  idti_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .uword_i          (uword),
    .flags_o          (flags),
    .accept_i         (accept),
    .opcode_i         (s_axis_tuser[0]),
    .entry_index_i    (s_axis_tdata[3:0]),
    .raw_sample_i     (s_axis_tdata[15:4]),
    .entry_distance_i (s_axis_tdata[31:16]),
    .entries_in_use_i (eiu_q),
    .far_distance_i   (far_q),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .distance_out_o   (m_axis_tdata),
    .status_o         (m_axis_tuser)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_WRITTEN))
    else $error("result status out of range");

  a_zero_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == ST_WRITTEN) || (m_axis_tuser == ST_NOSEG)))
    |-> (m_axis_tdata == '0))
    else $error("write or no-segment result carries a distance");

  a_write_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_WRITE) && !m_axis_tvalid)
    |=> ##1 (m_axis_tvalid && (m_axis_tuser == ST_WRITTEN)))
    else $error("write item result missing");

endmodule
